// ----- rtl/rws_pkg.sv -----
// Shared constants, types and codes for the roulette-wheel selector.
package rws_pkg;

    localparam int MAX_ENTRIES  = 256;
    localparam int FITNESS_BITS = 32;

    localparam int IDX_W    = $clog2(MAX_ENTRIES);
    localparam int ACT_W    = IDX_W + 1;
    localparam int CNT_W    = 9;
    localparam int NCMP_W   = (CNT_W > ACT_W) ? CNT_W : ACT_W;
    localparam int TOTAL_W  = 40;
    localparam int FRAC_W   = 16;
    localparam int TARGET_W = FRAC_W + TOTAL_W;
    localparam int PREFIX_W = FITNESS_BITS + IDX_W;
    localparam int SHIFT_W  = PREFIX_W + FRAC_W;
    localparam int CMP_W    = (SHIFT_W > TARGET_W) ? SHIFT_W : TARGET_W;
    localparam int CAP_BIT  = 47;
    localparam int CAP_W    = (PREFIX_W > CAP_BIT + 1) ? PREFIX_W : CAP_BIT + 1;
    localparam int KIND_W   = 2;
    localparam int PICK_W   = 8;
    localparam int ENTRY_W  = 8;
    localparam int FIT_IN_W = 32;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(256);

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_PICK  = 2'd1,
        KIND_RETRY = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_LOAD,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_scan_ctrl;

endpackage

// ----- rtl/roulette_wheel_selector_core.sv -----
// Top level of the roulette-wheel selector: control, fitness table and result register.
//
//  Channel   Signals                                   Direction
//  in        i_in_valid / o_in_ready + request fields  into block
//  out       o_out_valid / i_out_ready + result fields out of block
//  cfg       i_cfg_we / i_cfg_data (entry_count)       into block
//
// A write request goes through three steps to a finished result: table read, update, result.
// A pick request adds one scan step per scanned entry, up to the active entry count - 1,
// set by the single read port of the fitness table. After reset the table is cleared
// one entry per cycle, all MAX_ENTRIES entries, before the first request is taken.
// Requests are handled one at a time; the next one is taken while a result waits.
module roulette_wheel_selector_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_func,
    input  logic [rws_pkg::ENTRY_W-1:0]    i_entry_index,
    input  logic [rws_pkg::FIT_IN_W-1:0]   i_fitness_value,
    input  logic [rws_pkg::FRAC_W-1:0]     i_random_fraction,
    input  logic                           i_second_of_pair,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rws_pkg::KIND_W-1:0]     o_result_kind,
    output logic [rws_pkg::PICK_W-1:0]     o_picked_index,
    input  logic                           i_cfg_we,
    input  logic [rws_pkg::CNT_W-1:0]      i_cfg_data
);
    import rws_pkg::*;

    t_state                  r_state;
    t_state                  n_state;
    logic [CNT_W-1:0]        r_entry_count;
    logic [TOTAL_W-1:0]      r_total;
    logic [PICK_W-1:0]       r_first_pick;
    logic [IDX_W-1:0]        r_clr;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_idx_ok;
    logic [FITNESS_BITS-1:0] r_fit;
    logic [FRAC_W-1:0]       r_frac;
    logic                    r_second;
    logic [IDX_W-1:0]        r_scan_idx;
    t_kind                   r_res_kind;
    logic [PICK_W-1:0]       r_res_idx;
    logic                    r_out_valid;
    t_kind                   r_out_kind;
    logic [PICK_W-1:0]       r_out_idx;

    logic                    in_acc;
    logic                    out_free;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [FITNESS_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]        ram_raddr;
    logic [FITNESS_BITS-1:0] ram_rdata;
    t_scan_ctrl              scan_ctrl;
    logic                    scan_hit;
    logic [NCMP_W-1:0]       cnt_ext;
    logic [NCMP_W-1:0]       act_n;
    logic [IDX_W-1:0]        last_idx;
    logic                    scan_done;
    logic [IDX_W-1:0]        scan_pick;
    logic [PICK_W-1:0]       pick8;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign cnt_ext = NCMP_W'(r_entry_count);
    always_comb begin
        if (cnt_ext < NCMP_W'(2)) begin
            act_n = NCMP_W'(2);
        end else if (cnt_ext > NCMP_W'(MAX_ENTRIES)) begin
            act_n = NCMP_W'(MAX_ENTRIES);
        end else begin
            act_n = cnt_ext;
        end
    end
    assign last_idx = IDX_W'(act_n - NCMP_W'(1));

    assign scan_done = scan_hit || ((r_scan_idx + IDX_W'(1)) == last_idx);
    assign scan_pick = scan_hit ? r_scan_idx : last_idx;
    assign pick8     = PICK_W'(scan_pick);

    rws_ram #(
        .WIDTH (FITNESS_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rws_scan u_scan (
        .i_clk      (i_clk),
        .i_ctrl     (scan_ctrl),
        .i_fraction (r_frac),
        .i_total    (r_total),
        .i_rd_data  (ram_rdata),
        .o_hit      (scan_hit)
    );

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = r_idx;
        ram_wdata      = r_fit;
        ram_raddr      = '0;
        scan_ctrl.load = 1'b0;
        scan_ctrl.step = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == IDX_W'(MAX_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                ram_raddr  = IDX_W'(i_entry_index);
                if (i_in_valid) begin
                    n_state = i_func ? S_LOAD : S_WRITE;
                end
            end
            S_WRITE: begin
                ram_we  = r_idx_ok;
                n_state = S_RESP;
            end
            S_LOAD: begin
                scan_ctrl.load = 1'b1;
                ram_raddr      = '0;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                scan_ctrl.step = 1'b1;
                ram_raddr      = r_scan_idx + IDX_W'(1);
                if (scan_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_entry_count <= COUNT_RESET;
            r_total       <= '0;
            r_first_pick  <= '0;
            r_clr         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_data;
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + IDX_W'(1);
            end
            if (r_state == S_WRITE && r_idx_ok) begin
                r_total <= r_total - TOTAL_W'(ram_rdata) + TOTAL_W'(r_fit);
            end
            if (r_state == S_SCAN && scan_done && !r_second) begin
                r_first_pick <= pick8;
            end
            if (r_state == S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_idx    <= IDX_W'(i_entry_index);
            r_idx_ok <= (32'(i_entry_index) < MAX_ENTRIES);
            r_fit    <= FITNESS_BITS'(i_fitness_value);
            r_frac   <= i_random_fraction;
            r_second <= i_second_of_pair;
        end
        if (r_state == S_LOAD) begin
            r_scan_idx <= '0;
        end else if (r_state == S_SCAN) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
        if (r_state == S_WRITE) begin
            r_res_kind <= KIND_WRITE;
            r_res_idx  <= '0;
        end else if (r_state == S_SCAN && scan_done) begin
            r_res_idx <= pick8;
            if (r_second && pick8 == r_first_pick) begin
                r_res_kind <= KIND_RETRY;
            end else begin
                r_res_kind <= KIND_PICK;
            end
        end
        if (r_state == S_RESP && out_free) begin
            r_out_kind <= r_res_kind;
            r_out_idx  <= r_res_idx;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_picked_index = r_out_idx;

endmodule

// ----- rtl/rws_ram.sv -----
// Generic synchronous RAM with one write port and one registered read port.
module rws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rws_scan.sv -----
// Target scaling and prefix-sum accumulator with the hit compare of a pick.
module rws_scan (
    input  logic                          i_clk,
    input  rws_pkg::t_scan_ctrl           i_ctrl,
    input  logic [rws_pkg::FRAC_W-1:0]    i_fraction,
    input  logic [rws_pkg::TOTAL_W-1:0]   i_total,
    input  logic [rws_pkg::FITNESS_BITS-1:0] i_rd_data,
    output logic                          o_hit
);
    import rws_pkg::*;

    logic [TARGET_W-1:0] r_target;
    logic [PREFIX_W-1:0] r_prefix;
    logic [PREFIX_W-1:0] n_prefix;
    logic [SHIFT_W-1:0]  shifted;
    logic                over_cap;
    logic                reached;

    assign n_prefix = r_prefix + PREFIX_W'(i_rd_data);
    assign shifted  = {n_prefix, {FRAC_W{1'b0}}};
    assign over_cap = CAP_W'(n_prefix) > (CAP_W'(1) << CAP_BIT);
    assign reached  = CMP_W'(shifted) >= CMP_W'(r_target);
    assign o_hit    = over_cap || reached;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_target <= TARGET_W'(i_fraction) * TARGET_W'(i_total);
            r_prefix <= '0;
        end else if (i_ctrl.step) begin
            r_prefix <= n_prefix;
        end
    end

endmodule

// ----- dv/roulette_wheel_selector_core_tb.sv -----
// Self-checking testbench for the roulette-wheel selector core with random traffic and stalls.
module roulette_wheel_selector_core_tb;
    import rws_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int LONG_HOLD      = 600;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_REPORTS    = 10;
    localparam logic [63:0] CAP_LIMIT = 64'd1 << CAP_BIT;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PICK  = 1'b1;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    typedef struct packed {
        logic                func;
        logic [ENTRY_W-1:0]  idx;
        logic [FIT_IN_W-1:0] fit;
        logic [FRAC_W-1:0]   frac;
        logic                second;
    } t_sel_req;

    typedef struct packed {
        t_kind             kind;
        logic [PICK_W-1:0] index;
    } t_sel_res;

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                i_in_valid        = 1'b0;
    logic                o_in_ready;
    logic                i_func            = FUNC_WRITE;
    logic [ENTRY_W-1:0]  i_entry_index     = '0;
    logic [FIT_IN_W-1:0] i_fitness_value   = '0;
    logic [FRAC_W-1:0]   i_random_fraction = '0;
    logic                i_second_of_pair  = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready       = 1'b0;
    logic [KIND_W-1:0]   o_result_kind;
    logic [PICK_W-1:0]   o_picked_index;
    logic                i_cfg_we          = 1'b0;
    logic [CNT_W-1:0]    i_cfg_data        = '0;

    logic [FITNESS_BITS-1:0] wheel_fit [MAX_ENTRIES];
    logic [TOTAL_W-1:0]      wheel_total     = '0;
    logic [PICK_W-1:0]       first_pick_seen = '0;
    logic [CNT_W-1:0]        wheel_count     = COUNT_RESET;

    t_sel_req pending_reqs[$];
    t_sel_res expected_results[$];

    bit          req_taken    = 1'b0;
    int          idle_cycles  = 0;
    int          mismatches   = 0;
    int          gap_left     = 0;
    int          burst_left   = 1;
    bit          sender_gaps  = 1'b0;
    t_rx_mode    rx_mode      = RX_ALWAYS;
    logic [15:0] rx_pattern   = 16'hFFFF;
    int          rx_tick      = 0;
    bit          long_hold_on = 1'b0;
    int          hold_count   = 0;

    roulette_wheel_selector_core i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int active_entries(logic [CNT_W-1:0] cnt);
        if (cnt < 2) return 2;
        if (cnt > MAX_ENTRIES) return MAX_ENTRIES;
        return int'(cnt);
    endfunction

    function automatic t_sel_res predict_roulette(t_sel_req q);
        t_sel_res    res;
        logic [63:0] target;
        logic [63:0] prefix;
        int          n;
        res.kind  = KIND_WRITE;
        res.index = '0;
        if (q.func == FUNC_WRITE) begin
            if (q.idx < MAX_ENTRIES) begin
                wheel_total = wheel_total - TOTAL_W'(wheel_fit[q.idx])
                            + TOTAL_W'(FITNESS_BITS'(q.fit));
                wheel_fit[q.idx] = FITNESS_BITS'(q.fit);
            end
            return res;
        end
        n      = active_entries(wheel_count);
        target = 64'(q.frac) * 64'(wheel_total);
        prefix = '0;
        res.index = PICK_W'(n - 1);
        for (int i = 0; i < n - 1; i++) begin
            prefix += 64'(wheel_fit[i]);
            if (prefix > CAP_LIMIT || (prefix << FRAC_W) >= target) begin
                res.index = PICK_W'(i);
                break;
            end
        end
        res.kind = KIND_PICK;
        if (q.second) begin
            if (res.index == first_pick_seen) res.kind = KIND_RETRY;
        end else begin
            first_pick_seen = res.index;
        end
        return res;
    endfunction

    function automatic void queue_req(t_sel_req q);
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    function automatic t_sel_req write_req(logic [ENTRY_W-1:0] idx, logic [FIT_IN_W-1:0] fit);
        t_sel_req q;
        q        = '0;
        q.func   = FUNC_WRITE;
        q.idx    = idx;
        q.fit    = fit;
        q.frac   = FRAC_W'($urandom);
        q.second = 1'($urandom);
        return q;
    endfunction

    function automatic t_sel_req pick_req(logic [FRAC_W-1:0] frac, logic second);
        t_sel_req q;
        q        = '0;
        q.func   = FUNC_PICK;
        q.idx    = ENTRY_W'($urandom);
        q.fit    = $urandom;
        q.frac   = frac;
        q.second = second;
        return q;
    endfunction

    function automatic logic [FIT_IN_W-1:0] random_fitness();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 2) return '0;
        if (roll == 2) return '1;
        if (roll < 8) return FIT_IN_W'($urandom_range(0, 255));
        return $urandom;
    endfunction

    function automatic logic [FRAC_W-1:0] random_frac();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return FRAC_W'($urandom);
    endfunction

    // Most picks come as a first/second pair so that retries actually happen.
    function automatic int queue_random_items(int n, logic [CNT_W-1:0] cnt);
        int made;
        int roll;
        int span;
        made = 0;
        span = active_entries(cnt);
        while (made < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                queue_req(write_req(($urandom_range(0, 3) == 0) ?
                    ENTRY_W'($urandom) : ENTRY_W'($urandom_range(0, span - 1)),
                    random_fitness()));
                made++;
            end else if (roll < 85) begin
                queue_req(pick_req(random_frac(), 1'b0));
                queue_req(pick_req(random_frac(), 1'b1));
                made += 2;
            end else begin
                queue_req(pick_req(random_frac(), 1'($urandom)));
                made++;
            end
        end
        return made;
    endfunction

    function automatic void note_mismatch(string what, t_sel_res want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s at %0t: expected kind %0d index %0d, got kind %0d index %0d",
                     what, $time, want.kind, want.index, o_result_kind, o_picked_index);
    endfunction

    task automatic drain();
        while (pending_reqs.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_entry_count(logic [CNT_W-1:0] value);
        drain();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        wheel_count = value;
    endtask

    task automatic pick_traffic();
        sender_gaps = ($urandom_range(0, 2) != 0);
        rx_mode     = t_rx_mode'($urandom_range(0, 2));
        rx_pattern  = 16'($urandom) | 16'h0001;
    endtask

    always @(negedge i_clk) begin : sender
        t_sel_req nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                nxt = pending_reqs.pop_front();
                i_func            <= nxt.func;
                i_entry_index     <= nxt.idx;
                i_fitness_value   <= nxt.fit;
                i_random_fraction <= nxt.frac;
                i_second_of_pair  <= nxt.second;
                i_in_valid        <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = sender_gaps ? $urandom_range(1, 12) : 0;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        rx_tick++;
        if (long_hold_on && hold_count < LONG_HOLD) begin
            hold_count++;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: i_out_ready <= 1'b1;
                RX_RANDOM: i_out_ready <= ($urandom_range(0, 99) < 60);
                default:   i_out_ready <= rx_pattern[rx_tick % 16];
            endcase
        end
    end

    always @(posedge i_clk) begin : monitor
        t_sel_res want;
        t_sel_req req;
        bit       res_taken;
        req_taken = i_rst_n && i_in_valid && o_in_ready;
        res_taken = i_rst_n && o_out_valid && i_out_ready;
        if (res_taken) begin
            if (expected_results.size() == 0) begin
                want = '0;
                note_mismatch("unrequested result", want);
            end else begin
                want = expected_results.pop_front();
                if (o_result_kind !== want.kind || o_picked_index !== want.index)
                    note_mismatch("wrong result", want);
            end
        end
        if (req_taken) begin
            req = '{func: i_func, idx: i_entry_index, fit: i_fitness_value,
                    frac: i_random_fraction, second: i_second_of_pair};
            expected_results.insert(expected_results.size(), predict_roulette(req));
        end
        if (req_taken || res_taken || i_cfg_we) idle_cycles = 0;
        else idle_cycles++;
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int               random_made;
        int               n_items;
        int               phase;
        int               roll;
        logic [CNT_W-1:0] cnt;
        foreach (wheel_fit[i]) wheel_fit[i] = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The table starts empty, so the first picks land on entry zero.
        pick_traffic();
        queue_req(pick_req(16'h0000, 1'b0));
        queue_req(pick_req(16'hFFFF, 1'b1));
        queue_req(write_req(8'd0, 32'hFFFF_FFFF));
        queue_req(write_req(8'd255, 32'hFFFF_FFFF));
        queue_req(write_req(8'd128, 32'h8000_0000));
        queue_req(pick_req(16'h0000, 1'b0));
        queue_req(pick_req(16'hFFFF, 1'b1));
        queue_req(pick_req(16'h8000, 1'b0));
        queue_req(pick_req(16'h7FFF, 1'b1));
        queue_req(write_req(8'd0, 32'h0));
        queue_req(pick_req(16'h0000, 1'b0));
        queue_req(pick_req(16'h0001, 1'b1));

        // With two active entries, the heavy entries beyond the count fall on the last one.
        set_entry_count(9'd2);
        pick_traffic();
        queue_req(write_req(8'd1, 32'h0000_0055));
        queue_req(pick_req(16'h0001, 1'b0));
        queue_req(pick_req(16'hFFFF, 1'b1));
        queue_req(write_req(8'd1, 32'h0));

        set_entry_count(9'd0);
        queue_req(pick_req(16'h1234, 1'b0));
        queue_req(pick_req(16'h1234, 1'b1));
        set_entry_count(9'd1);
        queue_req(pick_req(16'hFFFF, 1'b0));
        set_entry_count(9'h1FF);
        queue_req(pick_req(16'hFFFF, 1'b0));
        queue_req(pick_req(16'h0001, 1'b1));
        set_entry_count(9'd255);
        queue_req(pick_req(16'hC000, 1'b0));
        queue_req(write_req(8'd254, 32'hAAAA_5555));
        queue_req(pick_req(16'hFFFF, 1'b1));

        random_made = 0;
        phase       = 0;
        while (random_made < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 19);
            if (phase == 2) begin
                cnt     = CNT_W'($urandom_range(2, 8));
                n_items = 120;
            end else if (roll == 0) begin
                cnt     = 9'd256;
                n_items = 20;
            end else if (roll == 1) begin
                cnt     = CNT_W'($urandom_range(257, 511));
                n_items = 15;
            end else if (roll == 2) begin
                cnt     = CNT_W'($urandom_range(0, 1));
                n_items = 60;
            end else if (roll == 3) begin
                cnt     = CNT_W'($urandom_range(17, 255));
                n_items = 25;
            end else begin
                cnt     = CNT_W'($urandom_range(2, 16));
                n_items = $urandom_range(60, 120);
            end
            set_entry_count(cnt);
            pick_traffic();
            // One phase keeps the output blocked while requests keep coming.
            long_hold_on = (phase == 2);
            if (phase == 2) sender_gaps = 1'b0;
            random_made += queue_random_items(n_items, cnt);
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
